### src/fnvht_pkg.sv
// Package for the FNV-1 linear probe hash table: widths, codes, hash constants.
package fnvht_pkg;

   localparam int TableSlotsDefault  = 64;
   localparam int MaxKeyBytesDefault = 8;

   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [63:0] FNV_MULT  = 64'h00000100000001b3;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_GET    = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HASH,
      S_CLEAR,
      S_PROBE,
      S_WRITE,
      S_OUT
   } state_type;

   // hash unit handshake
   typedef struct packed {
      logic        start;
      logic [63:0] key;
      logic [3:0]  len;
   } hash_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] hash;
   } hash_rsp_type;

endpackage

### src/fnvht_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module fnvht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### src/fnvht_hash.sv
// Iterative FNV-1 64-bit hash: one byte per step, multiply split into a low product and a shifted add.
module fnvht_hash
   import fnvht_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  hash_req_type req,
   output hash_rsp_type rsp
);

   logic [63:0] h_ff, h_in;
   logic [63:0] key_ff, key_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        phase_ff, phase_in;
   logic        done_ff, done_in;
   logic [63:0] part_ff, part_in;

   // h * (2^40 + 0x1b3): the first phase forms the low product, the second adds the shifted part
   always_comb begin
      h_in     = h_ff;
      key_in   = key_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      phase_in = phase_ff;
      done_in  = 1'b0;
      part_in  = part_ff;
      if (req.start) begin
         h_in     = FNV_BASIS;
         key_in   = req.key;
         cnt_in   = req.len;
         busy_in  = 1'b1;
         phase_in = 1'b0;
      end else if (busy_ff) begin
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (!phase_ff) begin
            part_in  = h_ff * 64'h1b3;
            phase_in = 1'b1;
         end else begin
            h_in     = (part_ff + {h_ff[23:0], 40'd0}) ^ {56'd0, key_ff[7:0]};
            key_in   = {8'd0, key_ff[63:8]};
            cnt_in   = cnt_ff - 4'd1;
            phase_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      h_ff     <= h_in;
      key_ff   <= key_in;
      cnt_ff   <= cnt_in;
      phase_ff <= phase_in;
      part_ff  <= part_in;
   end

   assign rsp.done = done_ff;
   assign rsp.hash = h_ff;

endmodule

### src/fnv1_linear_probe_hash_table_core.sv
// FNV-1 hashed open-addressing table with linear probing, slot data in one RAM.
// The hash takes the key a byte at a time (and is reduced a byte at a time when TABLE_SLOTS is
// not a power of two), then slots are probed in turn (up to TABLE_SLOTS, pipelined reads).
// One word in flight: no new word is accepted until the last result is loaded for output.
// After reset the slot RAM is swept clear one slot at a time; no word is accepted meanwhile.
module fnv1_linear_probe_hash_table_core
   import fnvht_pkg::*;
#(
   parameter int TABLE_SLOTS   = TableSlotsDefault,
   parameter int MAX_KEY_BYTES = MaxKeyBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_key_bytes,
   input  logic [3:0]  req_key_length,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_found,
   output logic [31:0] rsp_found_value,
   output logic [5:0]  rsp_slot_index
);

   localparam int AW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CW  = $clog2(TABLE_SLOTS + 1);
   localparam int EW  = 1 + 4 + 64 + 32;
   localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);
   localparam logic [3:0]    MAXLEN  = 4'(MAX_KEY_BYTES);

   state_type state_ff, state_in;

   logic [1:0]    op_ff, op_in;
   logic [63:0]   key_ff, key_in;
   logic [3:0]    len_ff, len_in;
   logic [31:0]   val_ff, val_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] addr_ff, addr_in;     // next slot to read
   logic [CW-1:0] issued_ff, issued_in; // reads issued
   logic [CW-1:0] seen_ff, seen_in;     // reads checked
   logic [AW-1:0] chk_ff, chk_in;       // slot of the data now on the RAM output
   logic          rvalid_ff, rvalid_in;
   logic [AW-1:0] hit_ff, hit_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    status_ff, status_in;
   logic          found_ff, found_in;
   logic [31:0]   fval_ff, fval_in;
   logic [5:0]    sidx_ff, sidx_in;

   // output word, held while the receiver stalls
   logic [1:0]    rsp_status_ff;
   logic          rsp_found_ff;
   logic [31:0]   rsp_fval_ff;
   logic [5:0]    rsp_sidx_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;

   hash_req_type  hreq;
   hash_rsp_type  hrsp;

   // slot word: used, length, key, value
   logic          e_used;
   logic [3:0]    e_len;
   logic [63:0]   e_key;
   logic [31:0]   e_val;
   assign {e_used, e_len, e_key, e_val} = rd_data;

   logic [3:0]  len_sat;
   logic [63:0] key_masked;
   logic [AW-1:0] start_slot;
   logic          slot_ready;

   always_comb begin
      len_sat = (req_key_length > MAXLEN) ? MAXLEN : req_key_length;
      for (int b = 0; b < 8; b++) begin
         key_masked[8*b +: 8] = (4'(b) < len_sat) ? req_key_bytes[8*b +: 8] : 8'd0;
      end
   end

   // modulo a power of two is a mask; other sizes reduce a byte at a time
   generate
      if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0) begin : g_pow2
         assign start_slot = (TABLE_SLOTS > 1) ? AW'(hrsp.hash) : '0;
         assign slot_ready = hrsp.done;
      end else begin : g_mod
         localparam int XW = AW + 8;
         localparam int PW = AW + 40;
         localparam logic [31:0]   RECIP   = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));
         localparam logic [XW-1:0] SLOTS_X = XW'(TABLE_SLOTS);

         logic [63:0]   md_h_ff, md_h_in;
         logic [XW-1:0] md_x_ff, md_x_in;
         logic [XW-1:0] md_q_ff, md_q_in;
         logic [AW-1:0] md_r_ff, md_r_in;
         logic [2:0]    md_cnt_ff, md_cnt_in;
         logic          md_phase_ff, md_phase_in;
         logic          md_busy_ff, md_busy_in;
         logic          md_done_ff, md_done_in;
         logic [PW-1:0] md_prod;
         logic [XW-1:0] md_rem;

         // top byte first; for each byte a quotient estimate from a
         // fixed-point reciprocal, then remainder with one correction
         always_comb begin
            md_h_in     = md_h_ff;
            md_x_in     = md_x_ff;
            md_q_in     = md_q_ff;
            md_r_in     = md_r_ff;
            md_cnt_in   = md_cnt_ff;
            md_phase_in = md_phase_ff;
            md_busy_in  = md_busy_ff;
            md_done_in  = 1'b0;
            md_prod     = PW'(md_x_ff) * PW'(RECIP);
            md_rem      = md_x_ff - md_q_ff * SLOTS_X;
            if (md_rem >= SLOTS_X) begin
               md_rem = md_rem - SLOTS_X;
            end
            if (hrsp.done) begin
               md_h_in     = {hrsp.hash[55:0], 8'd0};
               md_x_in     = {AW'(0), hrsp.hash[63:56]};
               md_cnt_in   = 3'd7;
               md_phase_in = 1'b0;
               md_busy_in  = 1'b1;
            end else if (md_busy_ff) begin
               if (!md_phase_ff) begin
                  md_q_in     = md_prod[PW-1:32];
                  md_phase_in = 1'b1;
               end else if (md_cnt_ff == 3'd0) begin
                  md_r_in    = AW'(md_rem);
                  md_busy_in = 1'b0;
                  md_done_in = 1'b1;
               end else begin
                  md_x_in     = {AW'(md_rem), md_h_ff[63:56]};
                  md_h_in     = {md_h_ff[55:0], 8'd0};
                  md_cnt_in   = md_cnt_ff - 3'd1;
                  md_phase_in = 1'b0;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               md_busy_ff <= 1'b0;
               md_done_ff <= 1'b0;
            end else begin
               md_busy_ff <= md_busy_in;
               md_done_ff <= md_done_in;
            end
            md_h_ff     <= md_h_in;
            md_x_ff     <= md_x_in;
            md_q_ff     <= md_q_in;
            md_r_ff     <= md_r_in;
            md_cnt_ff   <= md_cnt_in;
            md_phase_ff <= md_phase_in;
         end

         assign start_slot = md_r_ff;
         assign slot_ready = md_done_ff;
      end
   endgenerate

   assign hreq.start = (state_ff == S_IDLE) && req_valid;
   assign hreq.key   = key_masked;
   assign hreq.len   = len_sat;

   fnvht_hash u_hash (
      .clock (clock),
      .reset (reset),
      .req   (hreq),
      .rsp   (hrsp)
   );

   fnvht_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   function automatic logic [AW-1:0] inc_slot(input logic [AW-1:0] a);
      return (a == AW'(TABLE_SLOTS - 1)) ? '0 : a + AW'(1);
   endfunction

   logic e_match;
   assign e_match = e_used && (e_len == len_ff) && (e_key == key_ff);

   // next state, probe control and result
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      len_in       = len_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      issued_in    = issued_ff;
      seen_in      = seen_ff;
      chk_in       = chk_ff;
      rvalid_in    = 1'b0;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      found_in     = found_ff;
      fval_in      = fval_ff;
      sidx_in      = sidx_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = '0;
      rd_addr      = addr_ff;
      req_stall    = 1'b1;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            addr_in = inc_slot(addr_ff);
            if (addr_ff == AW'(TABLE_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in    = req_op;
               key_in   = key_masked;
               len_in   = len_sat;
               val_in   = req_value;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (slot_ready) begin
               status_in = ST_OK;
               found_in  = 1'b0;
               fval_in   = '0;
               sidx_in   = '0;
               addr_in   = start_slot;
               issued_in = '0;
               seen_in   = '0;
               state_in  = S_PROBE;
               case (op_type'(op_ff))
                  OP_ADD:    if (count_ff == SLOTS_C) begin
                     status_in = ST_FULL;
                     state_in  = S_OUT;
                  end
                  OP_REMOVE: if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_OUT;
                  end
                  OP_GET:    if (count_ff == '0) begin
                     status_in = ST_MISSING;
                     state_in  = S_OUT;
                  end
                  default:   state_in = S_OUT;
               endcase
            end
         end
         S_PROBE: begin
            // issue one read a cycle, check the one returned
            if (issued_ff < SLOTS_C) begin
               rd_addr   = addr_ff;
               chk_in    = addr_ff;
               rvalid_in = 1'b1;
               addr_in   = inc_slot(addr_ff);
               issued_in = issued_ff + CW'(1);
            end
            if (rvalid_ff) begin
               seen_in = seen_ff + CW'(1);
               if ((op_ff == OP_ADD) ? !e_used : e_match) begin
                  rvalid_in = 1'b0;
                  hit_in    = chk_ff;
                  sidx_in   = 6'(chk_ff);
                  if (op_ff == OP_GET) begin
                     found_in = 1'b1;
                     fval_in  = e_val;
                     state_in = S_OUT;
                  end else begin
                     found_in = (op_ff == OP_REMOVE);
                     state_in = S_WRITE;
                  end
               end else if (seen_ff + CW'(1) == SLOTS_C) begin
                  rvalid_in = 1'b0;
                  status_in = (op_ff == OP_ADD) ? ST_FULL : ST_MISSING;
                  state_in  = S_OUT;
               end
            end
         end
         S_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = hit_ff;
            if (op_ff == OP_ADD) begin
               wr_data  = {1'b1, len_ff, key_ff, val_ff};
               count_in = count_ff + CW'(1);
            end else begin
               count_in = count_ff - CW'(1);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         count_ff     <= '0;
         addr_ff      <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      len_ff    <= len_in;
      val_ff    <= val_in;
      issued_ff <= issued_in;
      seen_ff   <= seen_in;
      chk_ff    <= chk_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      fval_ff   <= fval_in;
      sidx_ff   <= sidx_in;
      // load the output word when the result leaves
      if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_ff;
         rsp_fval_ff   <= fval_ff;
         rsp_sidx_ff   <= sidx_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_found_value = rsp_fval_ff;
   assign rsp_slot_index  = rsp_sidx_ff;

endmodule
